FILE: hw/rtl/srti_pkg.sv
`default_nettype none

package srti_pkg;

    localparam int DEF_MAX_ENTRIES = 128;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ZERO   = 3'd1,
        ST_PREV   = 3'd2,
        ST_NEXT   = 3'd3,
        ST_FULL   = 3'd4,
        ST_BADIDX = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_READ,
        S_SCAN_ISSUE,
        S_SCAN,
        S_CHECK,
        S_SHIFT_ISSUE,
        S_SHIFT,
        S_PLACE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [63:0] start_lba;
        logic [63:0] end_lba;
    } t_range;

    typedef struct packed {
        logic        op;
        logic [63:0] start_lba;
        logic [63:0] end_lba;
        logic [6:0]  index;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  position;
        logic [7:0]  entry_total;
        logic [63:0] read_start;
        logic [63:0] read_end;
    } t_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/srti_table.sv
`default_nettype none

module srti_table
    import srti_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ENTRIES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_range        i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_range             o_rd_data
);

    t_range r_mem [DEPTH];
    t_range r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_range_table_insert_top.sv
// Sorted sector-range table.
// Request channel (i_in_valid / o_in_ready, payload i_in_req) carries either an
// insert of a range (start, end) or a read of the entry at an index. Response
// channel (o_out_valid / i_out_ready, payload o_out_rsp) returns one response
// per request: status, slot used, entry count and the range read.
// One request is handled at a time; o_in_ready is high only while idle, and the
// next request is taken in the cycle after the previous response is loaded.
// Steps to the response register: a read looks up the entry and reads it; an
// insert with a zero start goes straight to the response. Any other insert
// searches for the slot of the new range, checks it against its neighbours and
// the table size, moves later entries up, places the range and then loads the
// response.
// Search and move both run through the single read and write port of the
// table RAM, one entry per cycle.
// A finished response sits in an output register; the block goes back to idle
// and takes the next request while it waits. If the receiver stalls and that
// register is still full, the next response holds until it drains.
// Synchronous reset empties the table (count to zero) and drops any response.
// Table contents are not cleared; data read from slots at or above the count is never used.
`default_nettype none

module sorted_range_table_insert_top
    import srti_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_req,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_rsp
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = CW + 7;

    t_state        r_state, n_state;
    logic          r_op, n_op;
    logic [63:0]   r_start, n_start;
    logic [63:0]   r_end, n_end;
    logic [6:0]    r_index, n_index;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic [63:0]   r_prev_end, n_prev_end;
    logic [63:0]   r_next_start, n_next_start;
    logic          r_have_next, n_have_next;
    logic [AW-1:0] r_src, n_src;
    t_status       r_res_status, n_res_status;
    logic [6:0]    r_res_pos, n_res_pos;
    logic [63:0]   r_res_rs, n_res_rs;
    logic [63:0]   r_res_re, n_res_re;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out, n_out;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_range        wr_data;
    logic [AW-1:0] rd_addr;
    t_range        rd_data;
    logic          idx_ok;

    srti_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign idx_ok = (IW'(r_index) < IW'(r_count)) && (IW'(r_index) < IW'(MAX_ENTRIES));

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_start      = r_start;
        n_end        = r_end;
        n_index      = r_index;
        n_count      = r_count;
        n_pos        = r_pos;
        n_prev_end   = r_prev_end;
        n_next_start = r_next_start;
        n_have_next  = r_have_next;
        n_src        = r_src;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_res_rs     = r_res_rs;
        n_res_re     = r_res_re;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '{start_lba: r_start, end_lba: r_end};
        rd_addr      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_in_req.op;
                    n_start   = i_in_req.start_lba;
                    n_end     = i_in_req.end_lba;
                    n_index   = i_in_req.index;
                    n_pos     = '0;
                    n_res_pos = '0;
                    n_res_rs  = '0;
                    n_res_re  = '0;
                    if (i_in_req.op == OP_READ) begin
                        n_state = S_LOOKUP;
                    end else if (i_in_req.start_lba == 64'd0) begin
                        n_res_status = ST_ZERO;
                        n_state      = S_RESP;
                    end else begin
                        n_state = S_SCAN_ISSUE;
                    end
                end
            end
            S_LOOKUP: begin
                rd_addr = AW'(r_index);
                n_state = S_READ;
            end
            S_READ: begin
                if (idx_ok) begin
                    n_res_status = ST_OK;
                    n_res_rs     = rd_data.start_lba;
                    n_res_re     = rd_data.end_lba;
                end else begin
                    n_res_status = ST_BADIDX;
                end
                n_state = S_RESP;
            end
            S_SCAN_ISSUE: begin
                rd_addr = AW'(r_pos);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                rd_addr = AW'(r_pos + CW'(1));
                if (r_pos == r_count) begin
                    n_have_next = 1'b0;
                    n_state     = S_CHECK;
                end else if (r_start < rd_data.start_lba) begin
                    n_have_next  = 1'b1;
                    n_next_start = rd_data.start_lba;
                    n_state      = S_CHECK;
                end else begin
                    n_prev_end = rd_data.end_lba;
                    n_pos      = r_pos + CW'(1);
                end
            end
            S_CHECK: begin
                if (r_pos != '0 && r_start <= r_prev_end) begin
                    n_res_status = ST_PREV;
                    n_state      = S_RESP;
                end else if (r_have_next && r_end >= r_next_start) begin
                    n_res_status = ST_NEXT;
                    n_state      = S_RESP;
                end else if (IW'(r_count) >= IW'(MAX_ENTRIES)) begin
                    n_res_status = ST_FULL;
                    n_state      = S_RESP;
                end else if (r_count > r_pos) begin
                    n_src   = AW'(r_count - CW'(1));
                    n_state = S_SHIFT_ISSUE;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_SHIFT_ISSUE: begin
                rd_addr = r_src;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_src + AW'(1);
                wr_data = rd_data;
                rd_addr = r_src - AW'(1);
                if (CW'(r_src) == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    n_src = r_src - AW'(1);
                end
            end
            S_PLACE: begin
                wr_en        = 1'b1;
                wr_addr      = AW'(r_pos);
                n_count      = r_count + CW'(1);
                n_res_status = ST_OK;
                n_res_pos    = 7'(r_pos);
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_res_status;
                    n_out.position    = r_res_pos;
                    n_out.entry_total = 8'(r_count);
                    n_out.read_start  = r_res_rs;
                    n_out.read_end    = r_res_re;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_start      <= n_start;
        r_end        <= n_end;
        r_index      <= n_index;
        r_pos        <= n_pos;
        r_prev_end   <= n_prev_end;
        r_next_start <= n_next_start;
        r_have_next  <= n_have_next;
        r_src        <= n_src;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_res_rs     <= n_res_rs;
        r_res_re     <= n_res_re;
        r_out        <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        IW'(r_count) <= IW'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
        (r_count == $past(r_count) + CW'(1) && $past(r_state) == S_PLACE
         && $past(r_op) == OP_INSERT))
        else $error("entry count changed outside a placement");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_CHECK) |-> r_pos <= r_count)
        else $error("search ran past the held entries");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT |-> (CW'(r_src) >= r_pos && CW'(r_src) < r_count))
        else $error("move source outside the entries to move");

endmodule

`default_nettype wire
